>>> rtl/core/hcr_pkg.sv
// ----------------------------------------------------------------------------
// hcr_pkg: shared types and constants of the health color ramp
// Holds the payload structs, the configuration codes, the stop color reset
// values and the stage structs that travel between the pipeline modules.
// ----------------------------------------------------------------------------
package hcr_pkg;

  // Channel and arithmetic widths.
  localparam int unsigned ChanW        = 8;
  localparam int unsigned NumChan      = 4;
  localparam int unsigned ColorW       = ChanW * NumChan;
  localparam int unsigned SpanW        = 15;
  localparam int unsigned NumW         = 23;
  localparam int unsigned QuoW         = 8;
  localparam int unsigned BitsPerStage = 2;
  localparam int unsigned NumDivStages = QuoW / BitsPerStage;

  // Configuration port widths.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ADJUST  = 3'd0,
    CFG_RED_LM  = 3'd1,
    CFG_RED_FB  = 3'd2,
    CFG_BLUE_LM = 3'd3,
    CFG_BLUE_FB = 3'd4
  } hcr_cfg_idx_e;

  // Team codes; any code above blue is treated as another team.
  localparam logic [1:0] TeamBlue = 2'd1;

  // Reset stop colors, red byte in bits 7:0 and alpha in bits 31:24.
  localparam logic [ColorW-1:0]   RedColor   = 32'hFF3B_38B8;
  localparam logic [ColorW-1:0]   BlueColor  = 32'hFFA2_8558;
  localparam logic [ColorW-1:0]   WhiteColor = 32'hFFFF_FFFF;
  localparam logic [CfgDataW-1:0] RedPair    = {RedColor, RedColor};
  localparam logic [CfgDataW-1:0] BluePair   = {BlueColor, BlueColor};

  // Reciprocal of five: floor(m * Div5Mul / 2^Div5Shift) equals m / 5 for 15-bit m.
  localparam logic [14:0] Div5Mul   = 15'd26215;
  localparam int unsigned Div5Shift = 17;

  // One input item.
  typedef struct packed {
    logic [1:0]         team;
    logic signed [15:0] health;
    logic [14:0]        max_health;
  } hcr_in_t;

  // One result item.
  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic [ChanW-1:0] alpha_out;
  } hcr_out_t;

  // Configuration register contents.
  typedef struct packed {
    logic                adjust_on;
    logic [CfgDataW-1:0] red_lm;
    logic [CfgDataW-1:0] red_fb;
    logic [CfgDataW-1:0] blue_lm;
    logic [CfgDataW-1:0] blue_fb;
  } hcr_cfg_t;

  // Selected segment: start and end colors, position and span (span never zero).
  typedef struct packed {
    logic              valid;
    logic [ColorW-1:0] from;
    logic [ColorW-1:0] to;
    logic [SpanW-1:0]  t;
    logic [SpanW-1:0]  span;
  } hcr_seg_t;

  // Division pipeline word: per channel partial remainder and quotient.
  typedef struct packed {
    logic                             valid;
    logic [NumChan-1:0][NumW-1:0]     rem;
    logic [NumChan-1:0][QuoW-1:0]     quo;
    logic [SpanW-1:0]                 span;
  } hcr_div_t;

endpackage

>>> rtl/core/hcr_select.sv
// ----------------------------------------------------------------------------
// hcr_select: segment selection
// Two register stages: the first takes the item and divides the maximum by
// five, the second finds the buffed maximum and picks stops, position and span.
// ----------------------------------------------------------------------------
module hcr_select (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  hcr_pkg::hcr_in_t in_i,
  input  hcr_pkg::hcr_cfg_t cfg_i,
  output hcr_pkg::hcr_seg_t seg_o
);
  import hcr_pkg::*;

  logic         s1_valid_q;
  hcr_in_t      s1_item_q;
  logic [12:0]  s1_fifth_q;
  logic [29:0]  fifth_prod;

  hcr_seg_t     seg_d;
  logic         s2_valid_q;
  hcr_seg_t     s2_seg_q;

  // Maximum health divided by five through the reciprocal.
  assign fifth_prod = 30'(in_i.max_health) * 30'(Div5Mul);

  // Stage one registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q  <= in_i;
    s1_fifth_q <= fifth_prod[Div5Shift +: 13];
  end

  // Buffed maximum, segment compare and stop selection.
  always_comb begin
    logic [14:0]        fifth3;
    logic [13:0]        half;
    logic [15:0]        bmax;
    logic signed [17:0] h_s;
    logic signed [17:0] two_h;
    logic signed [17:0] m_s;
    logic signed [17:0] b_s;
    logic signed [17:0] t_mid;
    logic signed [17:0] t_top;
    logic signed [17:0] span_top;
    logic [CfgDataW-1:0] lm;
    logic [CfgDataW-1:0] fb;

    fifth3   = 15'({2'b00, s1_fifth_q} * 15'd3);
    half     = fifth3[14:1];
    bmax     = 16'({2'b00, half} * 16'd5);
    h_s      = {{2{s1_item_q.health[15]}}, s1_item_q.health};
    two_h    = h_s <<< 1;
    m_s      = $signed({3'b000, s1_item_q.max_health});
    b_s      = $signed({2'b00, bmax});
    t_mid    = two_h - m_s;
    t_top    = h_s - m_s;
    span_top = b_s - m_s;

    lm = (s1_item_q.team == TeamBlue) ? cfg_i.blue_lm : cfg_i.red_lm;
    fb = (s1_item_q.team == TeamBlue) ? cfg_i.blue_fb : cfg_i.red_fb;

    seg_d.valid = s1_valid_q;
    seg_d.from  = fb[ColorW-1:0];
    seg_d.to    = fb[ColorW-1:0];
    seg_d.t     = '0;
    seg_d.span  = SpanW'(1);

    priority if (s1_item_q.team > TeamBlue) begin
      seg_d.from = WhiteColor;
    end else if (!cfg_i.adjust_on) begin
      seg_d.from = fb[ColorW-1:0];
    end else if (h_s < 0) begin
      seg_d.from = lm[ColorW-1:0];
    end else if (two_h < m_s) begin
      seg_d.from = lm[ColorW-1:0];
      seg_d.to   = lm[CfgDataW-1:ColorW];
      seg_d.t    = two_h[SpanW-1:0];
      seg_d.span = s1_item_q.max_health;
    end else if (h_s < m_s) begin
      seg_d.from = lm[CfgDataW-1:ColorW];
      seg_d.to   = fb[ColorW-1:0];
      seg_d.t    = t_mid[SpanW-1:0];
      seg_d.span = s1_item_q.max_health;
    end else if (h_s <= b_s) begin
      seg_d.from = fb[ColorW-1:0];
      seg_d.to   = fb[CfgDataW-1:ColorW];
      seg_d.t    = t_top[SpanW-1:0];
      seg_d.span = span_top[SpanW-1:0];
    end else begin
      seg_d.from = fb[CfgDataW-1:ColorW];
    end

    // A segment of zero span gives its start color.
    if (seg_d.span == '0) begin
      seg_d.t    = '0;
      seg_d.span = SpanW'(1);
    end
  end

  // Stage two registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= seg_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_seg_q <= seg_d;
  end

  always_comb begin
    seg_o       = s2_seg_q;
    seg_o.valid = s2_valid_q;
  end

endmodule

>>> rtl/core/hcr_blend.sv
// ----------------------------------------------------------------------------
// hcr_blend: interpolation numerators
// Forms start * span + t * (end - start) for each channel, one register stage.
// ----------------------------------------------------------------------------
module hcr_blend (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hcr_pkg::hcr_seg_t seg_i,
  output hcr_pkg::hcr_div_t div_o
);
  import hcr_pkg::*;

  hcr_div_t div_d;
  logic     valid_q;
  hcr_div_t div_q;

  // Numerator per channel; it is never negative and stays below 256 * span.
  always_comb begin
    logic [NumW-1:0]   a_span;
    logic signed [8:0] diff;
    logic signed [24:0] t_s;
    logic signed [24:0] d_s;
    logic signed [24:0] prod;
    logic signed [24:0] num;

    div_d.valid = seg_i.valid;
    div_d.span  = seg_i.span;
    div_d.quo   = '0;
    div_d.rem   = '0;
    for (int c = 0; c < NumChan; c++) begin
      a_span = NumW'(seg_i.from[c*ChanW +: ChanW]) * NumW'(seg_i.span);
      diff   = $signed({1'b0, seg_i.to[c*ChanW +: ChanW]})
             - $signed({1'b0, seg_i.from[c*ChanW +: ChanW]});
      t_s    = $signed({10'b0, seg_i.t});
      d_s    = {{16{diff[8]}}, diff};
      prod   = t_s * d_s;
      num    = $signed({2'b00, a_span}) + prod;
      div_d.rem[c] = num[NumW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= div_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  always_comb begin
    div_o       = div_q;
    div_o.valid = valid_q;
  end

endmodule

>>> rtl/core/hcr_div_stage.sv
// ----------------------------------------------------------------------------
// hcr_div_stage: one stage of the restoring divider
// Resolves BitsPerStage quotient bits per channel, starting at FirstBit.
// ----------------------------------------------------------------------------
module hcr_div_stage #(
  parameter int unsigned FirstBit = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hcr_pkg::hcr_div_t div_i,
  output hcr_pkg::hcr_div_t div_o
);
  import hcr_pkg::*;

  hcr_div_t div_d;
  logic     valid_q;
  hcr_div_t div_q;

  // Compare and subtract the shifted divisor, one quotient bit a step.
  always_comb begin
    logic [NumW-1:0] divisor;

    div_d = div_i;
    for (int s = 0; s < BitsPerStage; s++) begin
      divisor = NumW'(div_i.span) << (FirstBit - s);
      for (int c = 0; c < NumChan; c++) begin
        if (div_d.rem[c] >= divisor) begin
          div_d.rem[c]                = div_d.rem[c] - divisor;
          div_d.quo[c][FirstBit - s]  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= div_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  always_comb begin
    div_o       = div_q;
    div_o.valid = valid_q;
  end

endmodule

>>> rtl/core/health_color_ramp_core.sv
// ----------------------------------------------------------------------------
// health_color_ramp_core: health to outline color ramp
// Interpolates each RGBA channel between the team's stop colors by health.
//
//   Channel  Ports                                          Transfer
//   input    start_i, busy_o, in_i                          start_i && !busy_o
//   result   result_valid_o, result_o                       result_valid_o
//   config   cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
//                                                           cfg_valid_i && cfg_ready_o
//
// One item is taken every cycle; busy_o stays low. A result reaches the result
// ports through the two select stages, the numerator stage and the four stages
// of the two-bit-per-stage divider. The pipeline never stalls, since the
// receiver cannot hold results off. Reset clears the valid bits and loads the
// stop colors and the adjust flag with their reset values.
// ----------------------------------------------------------------------------
module health_color_ramp_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  hcr_pkg::hcr_in_t               in_i,
  output logic                           result_valid_o,
  output hcr_pkg::hcr_out_t              result_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hcr_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [hcr_pkg::CfgDataW-1:0]   cfg_data_i
);
  import hcr_pkg::*;

  hcr_cfg_t cfg_q;
  hcr_cfg_t cfg_d;
  logic     accept;
  hcr_seg_t seg;
  hcr_div_t div_chain [NumDivStages+1];

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  // Configuration registers; out-of-range indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ADJUST:  cfg_d.adjust_on = cfg_data_i[0];
        CFG_RED_LM:  cfg_d.red_lm    = cfg_data_i;
        CFG_RED_FB:  cfg_d.red_fb    = cfg_data_i;
        CFG_BLUE_LM: cfg_d.blue_lm   = cfg_data_i;
        CFG_BLUE_FB: cfg_d.blue_fb   = cfg_data_i;
        default:     cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.adjust_on <= 1'b0;
      cfg_q.red_lm    <= RedPair;
      cfg_q.red_fb    <= RedPair;
      cfg_q.blue_lm   <= BluePair;
      cfg_q.blue_fb   <= BluePair;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Segment selection.
  hcr_select u_select (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_i),
    .cfg_i    (cfg_q),
    .seg_o    (seg)
  );

  // Numerators.
  hcr_blend u_blend (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seg_i  (seg),
    .div_o  (div_chain[0])
  );

  // Divider stages, most significant quotient bits first.
  for (genvar k = 0; k < NumDivStages; k++) begin : g_div
    hcr_div_stage #(
      .FirstBit (QuoW - 1 - BitsPerStage * k)
    ) u_div_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .div_i  (div_chain[k]),
      .div_o  (div_chain[k+1])
    );
  end

  // Result ports come straight from the last divider register.
  assign result_valid_o     = div_chain[NumDivStages].valid;
  assign result_o.red_out   = div_chain[NumDivStages].quo[0];
  assign result_o.green_out = div_chain[NumDivStages].quo[1];
  assign result_o.blue_out  = div_chain[NumDivStages].quo[2];
  assign result_o.alpha_out = div_chain[NumDivStages].quo[3];

endmodule
